// File: rtl/key_remap_table_macros.svh
// Assertion macros for the key remap table.
`ifndef KEY_REMAP_TABLE_MACROS_SVH
`define KEY_REMAP_TABLE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, off during reset.
`define KRT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, off during reset.
`define KRT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KRT_ASSERT_IMP(label, clk, rst, ante, cons)
`define KRT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/krt_pkg.sv
// Shared types and constants of the key remap table.
package krt_pkg;

  localparam int ENTRIES_DEFAULT = 64;
  localparam int KEY_W  = 16;
  localparam int FN_W   = 8;
  localparam int ART_W  = 8;
  localparam int SLOT_W = 6;

  typedef enum logic [1:0] {
    OP_ADD        = 2'd0,
    OP_LOOKUP     = 2'd1,
    OP_INVALIDATE = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_OOB       = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } state_t;

  // Request and partial answer that walks the row of entries.
  typedef struct packed {
    logic               valid;
    op_t                op;
    logic [KEY_W-1:0]   key;
    logic [FN_W-1:0]    fn;
    logic [ART_W-1:0]   art;
    logic [SLOT_W-1:0]  slot;
    logic               hit_found;
    logic               free_found;
    logic [KEY_W-1:0]   cap_key;
    logic [FN_W-1:0]    cap_fn;
    logic [ART_W-1:0]   cap_art;
    logic               cap_live;
  } probe_t;

  // Write command broadcast to all entries.
  typedef struct packed {
    logic               set_en;
    logic               clr_en;
    logic [KEY_W-1:0]   key;
    logic [FN_W-1:0]    fn;
    logic [ART_W-1:0]   art;
  } wr_t;

endpackage

// File: rtl/krt_cell.sv
// One table entry: holds a slot and forwards the search probe to its neighbor.
module krt_cell #(
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 6,
  parameter int CNT_W    = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [CNT_W-1:0]    used_count,
  input  krt_pkg::probe_t     probe_in,
  input  logic [IDX_W-1:0]    hit_idx_in,
  input  logic [IDX_W-1:0]    free_idx_in,
  output krt_pkg::probe_t     probe_out,
  output logic [IDX_W-1:0]    hit_idx_out,
  output logic [IDX_W-1:0]    free_idx_out,
  input  krt_pkg::wr_t        wr,
  input  logic [IDX_W-1:0]    wr_idx
);

  localparam int SEL_W = (IDX_W > krt_pkg::SLOT_W) ? IDX_W : krt_pkg::SLOT_W;
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic [krt_pkg::KEY_W-1:0] key;
  logic [krt_pkg::FN_W-1:0]  fn;
  logic [krt_pkg::ART_W-1:0] art;
  logic                      live;

  krt_pkg::probe_t           probe_next;
  logic [IDX_W-1:0]          hit_idx_next;
  logic [IDX_W-1:0]          free_idx_next;
  logic                      in_use;
  logic                      key_hit;
  logic                      wr_me;

  assign in_use = CNT_W'(CELL_IDX) < used_count;
  assign key_hit = probe_in.valid && live && in_use && (key == probe_in.key) &&
                   (probe_in.op != krt_pkg::OP_READ);
  assign wr_me = (wr_idx == MY_IDX);

  // Merge this entry into the probe
  always_comb begin
    probe_next    = probe_in;
    hit_idx_next  = hit_idx_in;
    free_idx_next = free_idx_in;
    if (key_hit && !probe_in.hit_found) begin
      probe_next.hit_found = 1'b1;
      probe_next.cap_fn    = fn;
      probe_next.cap_art   = art;
      hit_idx_next         = MY_IDX;
    end
    if (probe_in.valid && probe_in.op == krt_pkg::OP_ADD && !probe_in.free_found &&
        !live && in_use) begin
      probe_next.free_found = 1'b1;
      free_idx_next         = MY_IDX;
    end
    if (probe_in.valid && probe_in.op == krt_pkg::OP_READ &&
        SEL_W'(probe_in.slot) == SEL_W'(CELL_IDX)) begin
      probe_next.cap_key  = key;
      probe_next.cap_fn   = fn;
      probe_next.cap_art  = art;
      probe_next.cap_live = live;
    end
  end

  // Hand the probe to the next entry
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
    hit_idx_out  <= hit_idx_next;
    free_idx_out <= free_idx_next;
  end

  // Update the live bit
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (wr.set_en && wr_me) begin
      live <= 1'b1;
    end else if (wr.clr_en && wr_me) begin
      live <= 1'b0;
    end
  end

  // Store the entry payload
  always_ff @(posedge clk) begin
    if (wr.set_en && wr_me) begin
      key <= wr.key;
      fn  <= wr.fn;
      art <= wr.art;
    end
  end

endmodule

// File: rtl/krt_ctrl.sv
// Sequencer: launches the probe, decides the outcome at the tail and issues the write.
module krt_ctrl #(
  parameter int ENTRIES = krt_pkg::ENTRIES_DEFAULT,
  parameter int IDX_W   = $clog2(ENTRIES),
  parameter int CNT_W   = $clog2(ENTRIES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation,
  input  logic [krt_pkg::KEY_W-1:0]     key_code,
  input  logic [krt_pkg::FN_W-1:0]      function_in,
  input  logic [krt_pkg::ART_W-1:0]     art_in,
  input  logic [krt_pkg::SLOT_W-1:0]    slot_in,
  output krt_pkg::probe_t               head,
  input  krt_pkg::probe_t               tail,
  input  logic [IDX_W-1:0]              tail_hit_idx,
  input  logic [IDX_W-1:0]              tail_free_idx,
  output krt_pkg::wr_t                  wr,
  output logic [IDX_W-1:0]              wr_idx,
  output logic [CNT_W-1:0]              used_count,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [krt_pkg::SLOT_W-1:0]    slot_out,
  output logic [krt_pkg::KEY_W-1:0]     key_out,
  output logic [krt_pkg::FN_W-1:0]      function_out,
  output logic [krt_pkg::ART_W-1:0]     art_out,
  output logic                          entry_live
);

  localparam int CMP_W  = (CNT_W > krt_pkg::SLOT_W) ? CNT_W : krt_pkg::SLOT_W;
  localparam int WIDE_W = IDX_W + krt_pkg::SLOT_W;

  krt_pkg::state_t  state;
  krt_pkg::state_t  state_next;
  logic             finish;
  logic [CNT_W-1:0] used_count_next;

  krt_pkg::status_t            status_next;
  logic [IDX_W-1:0]            res_idx;
  logic [WIDE_W-1:0]           res_idx_wide;
  logic [krt_pkg::KEY_W-1:0]   key_next;
  logic [krt_pkg::FN_W-1:0]    fn_next;
  logic [krt_pkg::ART_W-1:0]   art_next;
  logic                        live_next;

  assign finish = (state == krt_pkg::S_SEARCH) && tail.valid;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      krt_pkg::S_IDLE: begin
        if (start) state_next = krt_pkg::S_SEARCH;
      end
      krt_pkg::S_SEARCH: begin
        if (tail.valid) state_next = krt_pkg::S_IDLE;
      end
      default: state_next = krt_pkg::S_IDLE;
    endcase
  end

  // Launch the probe and flag busy
  always_comb begin
    busy            = (state != krt_pkg::S_IDLE);
    head            = '0;
    head.valid      = start && !busy;
    head.op         = krt_pkg::op_t'(operation);
    head.key        = key_code;
    head.fn         = function_in;
    head.art        = art_in;
    head.slot       = slot_in;
  end

  // Decide the outcome when the probe leaves the last entry
  always_comb begin
    status_next     = krt_pkg::ST_OK;
    res_idx         = '0;
    key_next        = '0;
    fn_next         = '0;
    art_next        = '0;
    live_next       = 1'b0;
    used_count_next = used_count;
    wr              = '0;
    wr.key          = tail.key;
    wr.fn           = tail.fn;
    wr.art          = tail.art;
    case (tail.op)
      krt_pkg::OP_ADD: begin
        if (tail.hit_found) begin
          res_idx   = tail_hit_idx;
          wr.set_en = finish;
        end else if (tail.free_found) begin
          res_idx   = tail_free_idx;
          wr.set_en = finish;
        end else if (used_count < CNT_W'(ENTRIES)) begin
          res_idx   = IDX_W'(used_count);
          wr.set_en = finish;
          if (finish) used_count_next = used_count + CNT_W'(1);
        end else begin
          status_next = krt_pkg::ST_FULL;
        end
      end
      krt_pkg::OP_LOOKUP: begin
        if (tail.hit_found) begin
          res_idx  = tail_hit_idx;
          fn_next  = tail.cap_fn;
          art_next = tail.cap_art;
        end else begin
          status_next = krt_pkg::ST_NOT_FOUND;
        end
      end
      krt_pkg::OP_INVALIDATE: begin
        if (tail.hit_found) begin
          res_idx   = tail_hit_idx;
          wr.clr_en = finish;
        end else begin
          status_next = krt_pkg::ST_NOT_FOUND;
        end
      end
      krt_pkg::OP_READ: begin
        if (CMP_W'(tail.slot) >= CMP_W'(used_count)) begin
          status_next = krt_pkg::ST_OOB;
        end else begin
          res_idx   = IDX_W'(tail.slot);
          key_next  = tail.cap_key;
          fn_next   = tail.cap_fn;
          art_next  = tail.cap_art;
          live_next = tail.cap_live;
        end
      end
      default: status_next = krt_pkg::ST_OK;
    endcase
    wr_idx       = res_idx;
    res_idx_wide = WIDE_W'(res_idx);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= krt_pkg::S_IDLE;
      used_count <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      used_count <= used_count_next;
      done       <= finish;
    end
  end

  // Hold the result for its transfer cycle
  always_ff @(posedge clk) begin
    if (finish) begin
      status       <= status_next;
      slot_out     <= res_idx_wide[krt_pkg::SLOT_W-1:0];
      key_out      <= key_next;
      function_out <= fn_next;
      art_out      <= art_next;
      entry_live   <= live_next;
    end
  end

endmodule

// File: rtl/key_remap_table.sv
// Top level of the key remap table: sequencer and a row of entries.
//
// Key remap table of ENTRIES slots, each mapping a 16-bit key code to a function
// code and an art value. Pulse start while busy is low to hand over one request;
// the request is taken at that edge. For each request a probe walks the row of
// entries one slot per clock, collecting the first live key match, the first
// free slot and the indexed slot, and the sequencer then applies the write and
// registers the result. The result is shown for exactly one cycle while done
// is high, and the receiver cannot stall it, so it must capture it in that
// cycle. busy is already low in that cycle, so the next request may start
// there. Reset empties the table at once; the key, function and art stores
// are never read before being written.
module key_remap_table #(
  parameter int ENTRIES = krt_pkg::ENTRIES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    operation,
  input  logic [krt_pkg::KEY_W-1:0]     key_code,
  input  logic [krt_pkg::FN_W-1:0]      function_in,
  input  logic [krt_pkg::ART_W-1:0]     art_in,
  input  logic [krt_pkg::SLOT_W-1:0]    slot_in,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [krt_pkg::SLOT_W-1:0]    slot_out,
  output logic [krt_pkg::KEY_W-1:0]     key_out,
  output logic [krt_pkg::FN_W-1:0]      function_out,
  output logic [krt_pkg::ART_W-1:0]     art_out,
  output logic                          entry_live
);

  `include "key_remap_table_macros.svh"

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  krt_pkg::probe_t  probe    [ENTRIES+1];
  logic [IDX_W-1:0] hit_idx  [ENTRIES+1];
  logic [IDX_W-1:0] free_idx [ENTRIES+1];
  krt_pkg::wr_t     wr;
  logic [IDX_W-1:0] wr_idx;
  logic [CNT_W-1:0] used_count;

  assign hit_idx[0]  = '0;
  assign free_idx[0] = '0;

  krt_ctrl #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W),
    .CNT_W   (CNT_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .key_code      (key_code),
    .function_in   (function_in),
    .art_in        (art_in),
    .slot_in       (slot_in),
    .head          (probe[0]),
    .tail          (probe[ENTRIES]),
    .tail_hit_idx  (hit_idx[ENTRIES]),
    .tail_free_idx (free_idx[ENTRIES]),
    .wr            (wr),
    .wr_idx        (wr_idx),
    .used_count    (used_count),
    .done          (done),
    .status        (status),
    .slot_out      (slot_out),
    .key_out       (key_out),
    .function_out  (function_out),
    .art_out       (art_out),
    .entry_live    (entry_live)
  );

  // Row of entries, slot 0 first
  for (genvar i = 0; i < ENTRIES; i++) begin : g_row
    krt_cell #(
      .CELL_IDX (i),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
    ) u_entry (
      .clk          (clk),
      .rst          (rst),
      .used_count   (used_count),
      .probe_in     (probe[i]),
      .hit_idx_in   (hit_idx[i]),
      .free_idx_in  (free_idx[i]),
      .probe_out    (probe[i+1]),
      .hit_idx_out  (hit_idx[i+1]),
      .free_idx_out (free_idx[i+1]),
      .wr           (wr),
      .wr_idx       (wr_idx)
    );
  end

  // Checks on the sequencing and the fill count
  `KRT_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `KRT_ASSERT_IMP(a_done_after_busy, clk, rst, done, $past(busy))
  `KRT_ASSERT_NXT(a_count_step, clk, rst, 1'b1, (used_count == $past(used_count)) || (used_count == $past(used_count) + CNT_W'(1)))
  `KRT_ASSERT_IMP(a_full_at_cap, clk, rst, done && (status == krt_pkg::ST_FULL), used_count == CNT_W'(ENTRIES))

endmodule
